>>> rtl/core/vec_pkg.sv
// ----------------------------------------------------------------------------
// vec_pkg
// Types, constants and helpers shared by the edge colorer files.
// ----------------------------------------------------------------------------
package vec_pkg;

  localparam int MAX_VERTICES = 128;
  localparam int MAX_COLORS   = 64;
  localparam int VW           = 7;              // vertex number
  localparam int CW           = 7;              // color value 1..MAX_COLORS
  localparam int CIW          = 6;              // color index 0..MAX_COLORS-1
  localparam int NBW          = 8;              // vertex or none
  localparam int TBL_DEPTH    = MAX_VERTICES * MAX_COLORS;
  localparam int TBL_AW       = VW + CIW;
  localparam int CNT_W        = 13;
  localparam int JNL_DEPTH    = 4 * MAX_VERTICES;
  localparam int JNL_AW       = 9;
  localparam int JPW          = JNL_AW + 1;
  localparam int JNL_W        = 1 + VW + VW + CIW;
  localparam int CFG_W        = 6;

  localparam logic [NBW-1:0] NO_VERTEX = NBW'(MAX_VERTICES);

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_CONFLICT = 2'd1,
    ERR_NO_COLOR = 2'd2
  } err_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_READ, S_READ_DAT,
    S_SCAN_V, S_SCAN_W, S_SCAN_CHK,
    S_PATH_START, S_PATH_RD, S_PATH_CHK,
    S_FAN_V, S_FAN_U, S_FAN_CHK,
    S_FLIP_NEXT, S_FLIP_RD0, S_FLIP_RD1, S_FLIP_OP,
    S_OP_RDA, S_OP_RDB, S_OP_CHK, S_OP_WRA, S_OP_WRB, S_OP_NEXT,
    S_UNDO_RD, S_UNDO_CNT, S_UNDO_WRA, S_UNDO_WRB,
    S_CLEAR, S_OUT
  } state_t;

  // what follows a finished paint or erase
  typedef enum logic [2:0] {
    SP_FIRST, SP_FLIP, SP_FAN_ERASE, SP_FAN_PAINT_W, SP_FAN_PAINT_U,
    SP_FAN2_ERASE, SP_FAN2_PAINT_W
  } op_step_t;

  // path flip sequence
  typedef enum logic [2:0] {
    FL_ERASE_C1, FL_ERASE_C2, FL_PAINT_NEW, FL_PAINT_C2, FL_PAINT_C1, FL_DONE
  } flip_phase_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic [VW-1:0] vertex_a;
    logic [VW-1:0] vertex_b;
    logic [CW-1:0] query_color;
  } req_t;

  typedef struct packed {
    logic [CW-1:0]  edge_color;
    logic [NBW-1:0] neighbor;
    logic [CW-1:0]  colors_in_use;
    logic [1:0]     error;
  } rsp_t;

  function automatic logic [CIW-1:0] cidx(input logic [CW-1:0] c);
    logic [CW-1:0] cm;
    cm = c - CW'(1);
    return cm[CIW-1:0];
  endfunction

  function automatic logic [TBL_AW-1:0] slot(input logic [VW-1:0] v,
                                             input logic [CW-1:0] c);
    return {v, cidx(c)};
  endfunction

endpackage

>>> rtl/core/vec_stream_if.sv
// ----------------------------------------------------------------------------
// vec_stream_if
// Valid/ready channel carrying one payload word per request.
// ----------------------------------------------------------------------------
interface vec_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/vec_ram.sv
// ----------------------------------------------------------------------------
// vec_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module vec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/vizing_edge_colorer_unit.sv
// ----------------------------------------------------------------------------
// vizing_edge_colorer_unit
// Online edge colorer with at most max_degree+1 colors, built around one
// sequenced table access and compare unit.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake           | contents
//  request  | in  | valid/ready         | kind, vertex_a, vertex_b, query_color
//  result   | out | valid/ready         | edge_color, neighbor, colors_in_use,
//           |     |                     | error
//  apb      | in  | psel/penable/pready | max_degree at byte address 0
//
// one request at a time; ready only while idle. an add scans up to 64
// colors, then may step along a path and paint or erase edges, some as
// part of a path flip; all table traffic goes through the single read
// port of the table. an error undoes the logged paint/erase steps in
// reverse. after reset a sweep clears the neighbor table and the color
// counts before the first request is taken. a stalled result holds until
// taken; the next request may be accepted meanwhile.
// ----------------------------------------------------------------------------
module vizing_edge_colorer_unit (
  input  logic                clk,
  input  logic                rst,
  vec_stream_if.sink          request,
  vec_stream_if.source        result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import vec_pkg::*;

  state_t            state, state_next;
  op_step_t          step_q;
  flip_phase_t       phase_q;
  logic [CFG_W-1:0]  max_degree;
  logic [CW-1:0]     lim;
  logic [VW-1:0]     v_q, w_q, u_q, cur_q, prev_q, k_q, pass_q;
  logic [CW-1:0]     q_q, cs_q, c1_q, c2_q, c3_q;
  logic [7:0]        i_q;
  logic              op_paint_q;
  logic [VW-1:0]     op_a_q, op_b_q;
  logic [CW-1:0]     op_c_q;
  logic [NBW-1:0]    ra_q;
  logic [JPW-1:0]    jptr_q;
  logic [TBL_AW-1:0] sweep_q;
  logic [CW-1:0]     in_use_q;
  logic [CW-1:0]     res_color_q;
  logic [NBW-1:0]    res_nb_q;
  err_t              res_err_q;
  logic              out_valid_q;
  rsp_t              out_q;

  // memory ports
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
  logic [NBW-1:0]    tbl_wdata, tbl_rdata;
  logic              cnt_we;
  logic [CIW-1:0]    cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;
  logic              jnl_we;
  logic [JNL_AW-1:0] jnl_waddr, jnl_raddr;
  logic [JNL_W-1:0]  jnl_wdata, jnl_rdata;
  logic              path_we;
  logic [VW-1:0]     path_waddr, path_raddr, path_wdata, path_rdata;

  // shared compare logic
  logic              tbl_none, ra_none, scan_last, both_free, op_ok;
  logic              flip_more, cnt_inc, path_full, read_ok;
  logic [CW-1:0]     c1_eff, c2_eff, c3_eff, path_col, flip_col;
  logic [CNT_W-1:0]  cnt_new;
  logic [JPW-1:0]    jptr_dec;
  state_t            fail_state;

  vec_ram #(.WIDTH(NBW), .DEPTH(TBL_DEPTH)) u_table (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );
  vec_ram #(.WIDTH(CNT_W), .DEPTH(MAX_COLORS)) u_count (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );
  vec_ram #(.WIDTH(JNL_W), .DEPTH(JNL_DEPTH)) u_journal (
    .clk(clk), .we(jnl_we), .waddr(jnl_waddr), .wdata(jnl_wdata),
    .raddr(jnl_raddr), .rdata(jnl_rdata)
  );
  vec_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_path (
    .clk(clk), .we(path_we), .waddr(path_waddr), .wdata(path_wdata),
    .raddr(path_raddr), .rdata(path_rdata)
  );

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-CFG_W){1'b0}}, max_degree} : '0;

  // channel outputs
  assign request.ready  = (state == S_IDLE);
  assign result.valid   = out_valid_q;
  assign result.payload = out_q;

  // compare and select terms
  assign lim       = {1'b0, max_degree} + CW'(1);
  assign tbl_none  = (tbl_rdata == NO_VERTEX);
  assign ra_none   = (ra_q == NO_VERTEX);
  assign scan_last = (cs_q == lim);
  assign both_free = ra_none && tbl_none;
  assign c1_eff    = (c1_q == '0 && ra_none)  ? cs_q : c1_q;
  assign c2_eff    = (c2_q == '0 && tbl_none) ? cs_q : c2_q;
  assign c3_eff    = (c3_q == '0 && tbl_none) ? cs_q : c3_q;
  assign path_col  = k_q[0] ? c2_q : c1_q;
  assign path_full = (k_q == VW'(MAX_VERTICES - 1));
  assign flip_more = (i_q < {1'b0, k_q});
  assign flip_col  = (phase_q == FL_ERASE_C1 || phase_q == FL_PAINT_C1) ? c1_q : c2_q;
  assign jptr_dec  = jptr_q - JPW'(1);
  assign fail_state = (jptr_q != '0) ? S_UNDO_RD : S_OUT;
  assign read_ok   = (q_q != '0) && (q_q <= CW'(MAX_COLORS));
  assign op_ok     = (op_a_q != op_b_q) &&
                     (op_paint_q ? both_free
                                 : (ra_q == {1'b0, op_b_q} && tbl_rdata == {1'b0, op_a_q}));
  assign cnt_inc   = (state == S_OP_WRA) ? op_paint_q : !op_paint_q;
  assign cnt_new   = cnt_inc ? cnt_rdata + CNT_W'(1)
                   : ((cnt_rdata != '0) ? cnt_rdata - CNT_W'(1) : cnt_rdata);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (sweep_q == TBL_AW'(TBL_DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (request.valid) begin
          case (kind_t'(request.payload.kind))
            KIND_ADD: begin
              state_next = (request.payload.vertex_a == request.payload.vertex_b)
                           ? S_OUT : S_SCAN_V;
            end
            KIND_READ:  state_next = S_READ;
            KIND_CLEAR: state_next = S_CLEAR;
            default:    state_next = S_OUT;
          endcase
        end
      end
      S_READ:     state_next = read_ok ? S_READ_DAT : S_OUT;
      S_READ_DAT: state_next = S_OUT;
      S_SCAN_V:   state_next = S_SCAN_W;
      S_SCAN_W:   state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (both_free) state_next = S_OP_RDA;
        else if (scan_last) begin
          state_next = (c1_eff == '0 || c2_eff == '0) ? fail_state : S_PATH_START;
        end else state_next = S_SCAN_V;
      end
      S_PATH_START: state_next = S_PATH_RD;
      S_PATH_RD:    state_next = S_PATH_CHK;
      S_PATH_CHK: begin
        if (tbl_none) begin
          if (cur_q != v_q)   state_next = S_FLIP_NEXT;
          else if (k_q == '0) state_next = fail_state;
          else                state_next = S_FAN_V;
        end else if (path_full) state_next = fail_state;
        else state_next = S_PATH_RD;
      end
      S_FAN_V: state_next = S_FAN_U;
      S_FAN_U: state_next = S_FAN_CHK;
      S_FAN_CHK: begin
        if (both_free) state_next = S_OP_RDA;
        else if (scan_last) state_next = (c3_eff == '0) ? fail_state : S_OP_RDA;
        else state_next = S_FAN_V;
      end
      S_FLIP_NEXT: begin
        case (phase_q)
          FL_PAINT_NEW: state_next = S_OP_RDA;
          FL_DONE:      state_next = S_OUT;
          default:      state_next = flip_more ? S_FLIP_RD0 : S_FLIP_NEXT;
        endcase
      end
      S_FLIP_RD0: state_next = S_FLIP_RD1;
      S_FLIP_RD1: state_next = S_FLIP_OP;
      S_FLIP_OP:  state_next = S_OP_RDA;
      S_OP_RDA:   state_next = S_OP_RDB;
      S_OP_RDB:   state_next = S_OP_CHK;
      S_OP_CHK:   state_next = op_ok ? S_OP_WRA : fail_state;
      S_OP_WRA:   state_next = S_OP_WRB;
      S_OP_WRB:   state_next = S_OP_NEXT;
      S_OP_NEXT: begin
        case (step_q)
          SP_FIRST, SP_FAN_PAINT_U: state_next = S_OUT;
          SP_FLIP:                  state_next = S_FLIP_NEXT;
          SP_FAN2_PAINT_W: begin
            state_next = (u_q == v_q || pass_q == VW'(MAX_VERTICES - 1))
                         ? fail_state : S_PATH_START;
          end
          default:                  state_next = S_OP_RDA;
        endcase
      end
      S_UNDO_RD:  state_next = S_UNDO_CNT;
      S_UNDO_CNT: state_next = S_UNDO_WRA;
      S_UNDO_WRA: state_next = S_UNDO_WRB;
      S_UNDO_WRB: state_next = (jptr_dec == '0) ? S_OUT : S_UNDO_RD;
      S_CLEAR: begin
        if (sweep_q == TBL_AW'(TBL_DEPTH - 1)) state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || result.ready) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  // memory controls
  always_comb begin
    tbl_we     = 1'b0;
    tbl_waddr  = slot(op_a_q, op_c_q);
    tbl_wdata  = NO_VERTEX;
    tbl_raddr  = slot(op_a_q, op_c_q);
    cnt_we     = 1'b0;
    cnt_waddr  = cidx(op_c_q);
    cnt_wdata  = cnt_new;
    cnt_raddr  = cidx(op_c_q);
    jnl_we     = 1'b0;
    jnl_waddr  = jptr_q[JNL_AW-1:0];
    jnl_wdata  = {op_paint_q, op_a_q, op_b_q, cidx(op_c_q)};
    jnl_raddr  = jptr_dec[JNL_AW-1:0];
    path_we    = 1'b0;
    path_waddr = k_q + VW'(1);
    path_wdata = tbl_rdata[VW-1:0];
    path_raddr = i_q[VW-1:0];
    case (state)
      S_INIT, S_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = sweep_q;
        cnt_we    = (sweep_q[TBL_AW-1:CIW] == '0);
        cnt_waddr = sweep_q[CIW-1:0];
        cnt_wdata = '0;
      end
      S_READ:      tbl_raddr = slot(v_q, q_q);
      S_SCAN_V:    tbl_raddr = slot(v_q, cs_q);
      S_SCAN_W:    tbl_raddr = slot(w_q, cs_q);
      S_FAN_V:     tbl_raddr = slot(v_q, cs_q);
      S_FAN_U:     tbl_raddr = slot(u_q, cs_q);
      S_PATH_START: begin
        path_we    = 1'b1;
        path_waddr = '0;
        path_wdata = w_q;
      end
      S_PATH_RD:   tbl_raddr = slot(cur_q, path_col);
      S_PATH_CHK:  path_we = !tbl_none && !path_full;
      S_FLIP_RD1:  path_raddr = i_q[VW-1:0] + VW'(1);
      S_OP_RDB:    tbl_raddr = slot(op_b_q, op_c_q);
      S_OP_WRA: begin
        tbl_we    = 1'b1;
        tbl_wdata = op_paint_q ? {1'b0, op_b_q} : NO_VERTEX;
        cnt_we    = 1'b1;
      end
      S_OP_WRB: begin
        tbl_we    = 1'b1;
        tbl_waddr = slot(op_b_q, op_c_q);
        tbl_wdata = op_paint_q ? {1'b0, op_a_q} : NO_VERTEX;
        jnl_we    = 1'b1;
      end
      S_UNDO_CNT:  cnt_raddr = jnl_rdata[CIW-1:0];
      S_UNDO_WRA: begin
        tbl_we    = 1'b1;
        tbl_wdata = op_paint_q ? NO_VERTEX : {1'b0, op_b_q};
        cnt_we    = 1'b1;
      end
      S_UNDO_WRB: begin
        tbl_we    = 1'b1;
        tbl_waddr = slot(op_b_q, op_c_q);
        tbl_wdata = op_paint_q ? NO_VERTEX : {1'b0, op_a_q};
      end
      default: begin
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      sweep_q     <= '0;
      max_degree  <= CFG_W'(63);
      out_valid_q <= 1'b0;
      jptr_q      <= '0;
      in_use_q    <= '0;
    end else begin
      state <= state_next;
      // config write
      if (psel && penable && pwrite && paddr[2] == 1'b0) begin
        max_degree <= pwdata[CFG_W-1:0];
      end
      // result register
      if (state == S_OUT && (!out_valid_q || result.ready)) begin
        out_valid_q         <= 1'b1;
        out_q.edge_color    <= res_color_q;
        out_q.neighbor      <= res_nb_q;
        out_q.colors_in_use <= in_use_q;
        out_q.error         <= res_err_q;
      end else if (result.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state)
        S_INIT, S_CLEAR: begin
          sweep_q  <= sweep_q + TBL_AW'(1);
          in_use_q <= '0;
        end
        S_IDLE: begin
          if (request.valid) begin
            v_q         <= request.payload.vertex_a;
            w_q         <= request.payload.vertex_b;
            q_q         <= request.payload.query_color;
            cs_q        <= CW'(1);
            c1_q        <= '0;
            c2_q        <= '0;
            c3_q        <= '0;
            pass_q      <= '0;
            jptr_q      <= '0;
            sweep_q     <= '0;
            res_color_q <= '0;
            res_nb_q    <= NO_VERTEX;
            res_err_q   <= (kind_t'(request.payload.kind) == KIND_ADD &&
                            request.payload.vertex_a == request.payload.vertex_b)
                           ? ERR_CONFLICT : ERR_NONE;
          end
        end
        S_READ_DAT: res_nb_q <= tbl_rdata;
        S_SCAN_W, S_FAN_U, S_OP_RDB: ra_q <= tbl_rdata;
        S_SCAN_CHK: begin
          c1_q <= c1_eff;
          c2_q <= c2_eff;
          if (both_free) begin
            res_color_q <= cs_q;
            op_paint_q  <= 1'b1;
            op_a_q      <= v_q;
            op_b_q      <= w_q;
            op_c_q      <= cs_q;
            step_q      <= SP_FIRST;
          end else if (scan_last) begin
            if (c1_eff == '0 || c2_eff == '0) res_err_q <= ERR_NO_COLOR;
          end else begin
            cs_q <= cs_q + CW'(1);
          end
        end
        S_PATH_START: begin
          cur_q <= w_q;
          k_q   <= '0;
        end
        S_PATH_CHK: begin
          if (tbl_none) begin
            phase_q <= FL_ERASE_C1;
            i_q     <= '0;
            u_q     <= prev_q;
            cs_q    <= CW'(1);
            c3_q    <= '0;
            if (cur_q == v_q && k_q == '0) begin
              res_err_q   <= ERR_CONFLICT;
              res_color_q <= '0;
            end
          end else if (path_full) begin
            res_err_q   <= ERR_CONFLICT;
            res_color_q <= '0;
          end else begin
            k_q    <= k_q + VW'(1);
            prev_q <= cur_q;
            cur_q  <= tbl_rdata[VW-1:0];
          end
        end
        S_FAN_CHK: begin
          c3_q       <= both_free ? cs_q : c3_eff;
          op_paint_q <= 1'b0;
          op_a_q     <= v_q;
          op_b_q     <= u_q;
          op_c_q     <= c2_q;
          if (both_free) begin
            step_q <= SP_FAN_ERASE;
          end else if (scan_last) begin
            step_q <= SP_FAN2_ERASE;
            if (c3_eff == '0) begin
              res_err_q   <= ERR_NO_COLOR;
              res_color_q <= '0;
            end
          end else begin
            cs_q <= cs_q + CW'(1);
          end
        end
        S_FLIP_NEXT: begin
          case (phase_q)
            FL_PAINT_NEW: begin
              op_paint_q <= 1'b1;
              op_a_q     <= v_q;
              op_b_q     <= w_q;
              op_c_q     <= c1_q;
              step_q     <= SP_FLIP;
            end
            FL_DONE: begin
              if (pass_q == '0) res_color_q <= c1_q;
            end
            FL_ERASE_C1: begin
              if (!flip_more) begin
                phase_q <= FL_ERASE_C2;
                i_q     <= 8'd1;
              end
            end
            FL_ERASE_C2: begin
              if (!flip_more) phase_q <= FL_PAINT_NEW;
            end
            FL_PAINT_C2: begin
              if (!flip_more) begin
                phase_q <= FL_PAINT_C1;
                i_q     <= 8'd1;
              end
            end
            FL_PAINT_C1: begin
              if (!flip_more) phase_q <= FL_DONE;
            end
            default: phase_q <= FL_DONE;
          endcase
        end
        S_FLIP_RD1: op_a_q <= path_rdata;
        S_FLIP_OP: begin
          op_b_q     <= path_rdata;
          op_c_q     <= flip_col;
          op_paint_q <= (phase_q == FL_PAINT_C2 || phase_q == FL_PAINT_C1);
          step_q     <= SP_FLIP;
        end
        S_OP_CHK: begin
          if (!op_ok) begin
            res_err_q   <= ERR_CONFLICT;
            res_color_q <= '0;
          end
        end
        S_OP_WRA, S_UNDO_WRA: begin
          if (cnt_inc && cnt_rdata == '0) in_use_q <= in_use_q + CW'(1);
          if (!cnt_inc && cnt_rdata == CNT_W'(1)) in_use_q <= in_use_q - CW'(1);
        end
        S_OP_WRB: jptr_q <= jptr_q + JPW'(1);
        S_OP_NEXT: begin
          case (step_q)
            SP_FLIP: begin
              if (phase_q == FL_PAINT_NEW) begin
                phase_q <= FL_PAINT_C2;
                i_q     <= '0;
              end else begin
                i_q <= i_q + 8'd2;
              end
            end
            SP_FAN_ERASE, SP_FAN2_ERASE: begin
              op_paint_q <= 1'b1;
              op_a_q     <= v_q;
              op_b_q     <= w_q;
              op_c_q     <= c2_q;
              step_q     <= (step_q == SP_FAN_ERASE) ? SP_FAN_PAINT_W : SP_FAN2_PAINT_W;
            end
            SP_FAN_PAINT_W: begin
              op_paint_q <= 1'b1;
              op_a_q     <= v_q;
              op_b_q     <= u_q;
              op_c_q     <= c3_q;
              step_q     <= SP_FAN_PAINT_U;
            end
            SP_FAN_PAINT_U: begin
              if (pass_q == '0) res_color_q <= c2_q;
            end
            SP_FAN2_PAINT_W: begin
              if (u_q == v_q || pass_q == VW'(MAX_VERTICES - 1)) begin
                res_err_q   <= ERR_CONFLICT;
                res_color_q <= '0;
              end else begin
                if (pass_q == '0) res_color_q <= c2_q;
                w_q    <= u_q;
                c2_q   <= c3_q;
                pass_q <= pass_q + VW'(1);
              end
            end
            default: begin
            end
          endcase
        end
        S_UNDO_CNT: begin
          op_paint_q <= jnl_rdata[JNL_W-1];
          op_a_q     <= jnl_rdata[JNL_W-2 -: VW];
          op_b_q     <= jnl_rdata[CIW +: VW];
          op_c_q     <= {1'b0, jnl_rdata[CIW-1:0]} + CW'(1);
        end
        S_UNDO_WRB: jptr_q <= jptr_dec;
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTH
  // a failed add never reports a color
  a_err_no_color: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.payload.error != ERR_NONE) |->
      result.payload.edge_color == '0)
    else $error("error result carries a color");

  // rollback ends with an empty journal
  a_undo_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_UNDO_WRB && jptr_q == JPW'(1)) |=> (jptr_q == '0 && state == S_OUT))
    else $error("journal not empty after rollback");

  // color usage is stable while idle
  a_idle_in_use: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> (in_use_q == $past(in_use_q)))
    else $error("colors in use changed while idle");

  // journal stays within its memory
  a_jnl_bound: assert property (@(posedge clk) disable iff (rst)
    jptr_q <= JPW'(JNL_DEPTH))
    else $error("journal overflow");
`endif

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the edge colorer: a directed table followed by
// random graph phases at several max_degree settings, with every result
// checked against a fixed expectation or a behavioral model of the coloring and its table.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vec_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int NO_NB       = 128;
  localparam logic [2:0] ADDR_MAX_DEGREE = 3'd0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  vec_stream_if #(.payload_t(req_t)) request ();
  vec_stream_if #(.payload_t(rsp_t)) result ();

  vizing_edge_colorer_unit dut (
    .clk(clk), .rst(rst), .request(request), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // model state
  int   nb_tab[TBL_DEPTH];
  int   nb_save[TBL_DEPTH];
  int   edge_cnt[MAX_COLORS];
  int   cnt_save[MAX_COLORS];
  int   walk[MAX_VERTICES];
  int   max_deg = 63;

  rsp_t expected_q[$];
  int   mismatches = 0;
  int   cycles = 0;
  bit   out_busy = 1'b0;

  function automatic int across_of(int v, int c);
    if (v >= MAX_VERTICES || c < 1 || c > MAX_COLORS) return NO_NB;
    return nb_tab[v * MAX_COLORS + c - 1];
  endfunction

  function automatic bit paint_edge(int a, int b, int c);
    if (a == b || a >= MAX_VERTICES || b >= MAX_VERTICES || c < 1 || c > MAX_COLORS)
      return 1'b0;
    if (across_of(a, c) != NO_NB || across_of(b, c) != NO_NB) return 1'b0;
    nb_tab[a * MAX_COLORS + c - 1] = b;
    nb_tab[b * MAX_COLORS + c - 1] = a;
    edge_cnt[c - 1] = (edge_cnt[c - 1] + 1) & 13'h1FFF;
    return 1'b1;
  endfunction

  function automatic bit erase_edge(int a, int b, int c);
    if (a == b || a >= MAX_VERTICES || b >= MAX_VERTICES || c < 1 || c > MAX_COLORS)
      return 1'b0;
    if (across_of(a, c) != b || across_of(b, c) != a) return 1'b0;
    nb_tab[a * MAX_COLORS + c - 1] = NO_NB;
    nb_tab[b * MAX_COLORS + c - 1] = NO_NB;
    if (edge_cnt[c - 1] > 0) edge_cnt[c - 1]--;
    return 1'b1;
  endfunction

  // colors an edge v-w, returns the error code
  function automatic int color_edge(int v, int w, output int color);
    int lim, c, c1, c2, c3, k, i, u, pass, nx;
    color = 0;
    lim = (max_deg + 1 > MAX_COLORS) ? MAX_COLORS : max_deg + 1;
    for (c = 1; c <= lim; c++)
      if (across_of(v, c) == NO_NB && across_of(w, c) == NO_NB) begin
        if (!paint_edge(v, w, c)) return ERR_CONFLICT;
        color = c;
        return ERR_NONE;
      end
    for (c1 = 1; c1 <= lim && across_of(v, c1) != NO_NB; c1++);
    if (c1 > lim) return ERR_NO_COLOR;
    for (c2 = 1; c2 <= lim && across_of(w, c2) != NO_NB; c2++);
    if (c2 > lim) return ERR_NO_COLOR;
    for (pass = 0; pass < MAX_VERTICES; pass++) begin
      // walk the alternating c1/c2 path from w
      walk[0] = w;
      k = 0;
      while (1) begin
        nx = across_of(walk[k], (k & 1) ? c2 : c1);
        if (nx == NO_NB) break;
        if (k + 1 >= MAX_VERTICES) return ERR_CONFLICT;
        k++;
        walk[k] = nx;
      end
      // path misses v: flip it
      if (walk[k] != v) begin
        for (i = 0; i < k; i += 2)
          if (!erase_edge(walk[i], walk[i + 1], c1)) return ERR_CONFLICT;
        for (i = 1; i < k; i += 2)
          if (!erase_edge(walk[i], walk[i + 1], c2)) return ERR_CONFLICT;
        if (!paint_edge(v, w, c1)) return ERR_CONFLICT;
        for (i = 0; i < k; i += 2)
          if (!paint_edge(walk[i], walk[i + 1], c2)) return ERR_CONFLICT;
        for (i = 1; i < k; i += 2)
          if (!paint_edge(walk[i], walk[i + 1], c1)) return ERR_CONFLICT;
        if (pass == 0) color = c1;
        return ERR_NONE;
      end
      if (k == 0) return ERR_CONFLICT;
      // fan steps at the last path vertex
      u = walk[k - 1];
      for (c3 = 1; c3 <= lim; c3++)
        if (across_of(v, c3) == NO_NB && across_of(u, c3) == NO_NB) break;
      if (c3 <= lim) begin
        if (!erase_edge(v, u, c2) || !paint_edge(v, w, c2) || !paint_edge(v, u, c3))
          return ERR_CONFLICT;
        if (pass == 0) color = c2;
        return ERR_NONE;
      end
      for (c3 = 1; c3 <= lim && across_of(u, c3) != NO_NB; c3++);
      if (c3 > lim) return ERR_NO_COLOR;
      if (!erase_edge(v, u, c2) || !paint_edge(v, w, c2)) return ERR_CONFLICT;
      if (pass == 0) color = c2;
      if (u == v) return ERR_CONFLICT;
      w = u;
      c2 = c3;
    end
    return ERR_CONFLICT;
  endfunction

  // applies one request to the model and returns its result
  function automatic rsp_t predict_result(req_t r);
    rsp_t o;
    int color, err, nb, n, i;
    color = 0; nb = NO_NB; err = ERR_NONE;
    case (kind_t'(r.kind))
      KIND_ADD: begin
        if (r.vertex_a == r.vertex_b) begin
          err = ERR_CONFLICT;
        end else begin
          nb_save = nb_tab;
          cnt_save = edge_cnt;
          err = color_edge(r.vertex_a, r.vertex_b, color);
          if (err != ERR_NONE) begin
            nb_tab = nb_save;
            edge_cnt = cnt_save;
            color = 0;
          end
        end
      end
      KIND_READ: nb = across_of(r.vertex_a, r.query_color);
      KIND_CLEAR: begin
        for (i = 0; i < TBL_DEPTH; i++) nb_tab[i] = NO_NB;
        for (i = 0; i < MAX_COLORS; i++) edge_cnt[i] = 0;
      end
      default: ;
    endcase
    n = 0;
    for (i = 0; i < MAX_COLORS; i++) if (edge_cnt[i] != 0) n++;
    o.edge_color    = CW'(color);
    o.neighbor      = NBW'(nb);
    o.colors_in_use = CW'(n);
    o.error         = 2'(err);
    return o;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side stalls; quiet stretches come from out_busy
  int out_stall = 0;
  always @(posedge clk) begin
    if (rst || out_busy || out_stall == 0) begin
      result.ready <= 1'b1;
      if (!rst && !out_busy) out_stall <= gap_len();
    end else begin
      result.ready <= 1'b0;
      out_stall <= out_stall - 1;
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    cycles <= cycles + 1;
    if (!rst && result.valid && result.ready) begin
      if (expected_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected result %p", result.payload);
      end else begin
        want = expected_q.pop_front();
        if (result.payload.edge_color !== want.edge_color ||
            result.payload.neighbor !== want.neighbor ||
            result.payload.colors_in_use !== want.colors_in_use ||
            result.payload.error !== want.error) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected %p got %p", want, result.payload);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // one request on the input channel, with an idle gap of random length, possibly none, ahead of it
  task automatic send_request(req_t r, bit typed, rsp_t typed_rsp, bit no_gap);
    int g;
    rsp_t p;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      request.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    request.valid   <= 1'b1;
    request.payload <= r;
    do @(posedge clk); while (!request.ready);
    p = predict_result(r);
    expected_q.push_back(typed ? typed_rsp : p);
  endtask

  task automatic wait_idle();
    request.valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_max_degree(int v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_MAX_DEGREE; pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[5:0] !== 6'(v)) begin
      mismatches <= mismatches + 1;
      if (mismatches < 10) $display("max_degree readback %0d, wrote %0d", prdata, v);
    end
    psel <= 1'b0; penable <= 1'b0;
    max_deg = v;
  endtask

  typedef struct {
    bit    is_cfg;
    int    cfg_val;
    req_t  r;
    bit    typed;
    rsp_t  o;
  } dir_row_t;

  dir_row_t dir_tab[$];

  function automatic req_t mk_req(kind_t k, int a, int b, int q);
    req_t r;
    r.kind = k; r.vertex_a = VW'(a); r.vertex_b = VW'(b); r.query_color = CW'(q);
    return r;
  endfunction

  function automatic rsp_t mk_rsp(int c, int nb, int n, err_t e);
    rsp_t o;
    o.edge_color = CW'(c); o.neighbor = NBW'(nb); o.colors_in_use = CW'(n); o.error = e;
    return o;
  endfunction

  initial begin
    int   md_list[9] = '{1, 63, 2, 3, 5, 1, 4, 63, 17};
    int   i, ph, n, base, stride, sel, a, b, q, lim;
    bit   quiet;
    req_t r, no_req;
    rsp_t none;

    request.valid = 1'b0;
    request.payload = '0;
    result.ready = 1'b1;
    for (i = 0; i < TBL_DEPTH; i++) nb_tab[i] = NO_NB;
    for (i = 0; i < MAX_COLORS; i++) edge_cnt[i] = 0;
    none = '0;
    no_req = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table
    dir_tab.push_back('{0, 0, mk_req(KIND_READ, 0, 0, 1), 1, mk_rsp(0, 128, 0, ERR_NONE)});
    dir_tab.push_back('{0, 0, mk_req(KIND_NOP, 127, 127, 127), 1,
                        mk_rsp(0, 128, 0, ERR_NONE)});
    dir_tab.push_back('{0, 0, mk_req(KIND_ADD, 0, 1, 0), 1, mk_rsp(1, 128, 1, ERR_NONE)});
    dir_tab.push_back('{0, 0, mk_req(KIND_ADD, 5, 5, 0), 1,
                        mk_rsp(0, 128, 1, ERR_CONFLICT)});
    dir_tab.push_back('{0, 0, mk_req(KIND_ADD, 127, 126, 0), 1,
                        mk_rsp(1, 128, 1, ERR_NONE)});
    dir_tab.push_back('{0, 0, mk_req(KIND_READ, 0, 0, 1), 1, mk_rsp(0, 1, 1, ERR_NONE)});
    dir_tab.push_back('{0, 0, mk_req(KIND_READ, 127, 0, 1), 1, mk_rsp(0, 126, 1, ERR_NONE)});
    dir_tab.push_back('{0, 0, mk_req(KIND_READ, 0, 0, 0), 1, mk_rsp(0, 128, 1, ERR_NONE)});
    dir_tab.push_back('{0, 0, mk_req(KIND_READ, 0, 0, 127), 1, mk_rsp(0, 128, 1, ERR_NONE)});
    dir_tab.push_back('{0, 0, mk_req(KIND_READ, 3, 0, 64), 1, mk_rsp(0, 128, 1, ERR_NONE)});
    dir_tab.push_back('{0, 0, mk_req(KIND_ADD, 1, 0, 0), 0, none});
    dir_tab.push_back('{0, 0, mk_req(KIND_CLEAR, 0, 0, 0), 1, mk_rsp(0, 128, 0, ERR_NONE)});
    dir_tab.push_back('{1, 1, no_req, 0, none});
    dir_tab.push_back('{0, 0, mk_req(KIND_ADD, 0, 1, 0), 1, mk_rsp(1, 128, 1, ERR_NONE)});
    dir_tab.push_back('{0, 0, mk_req(KIND_ADD, 1, 2, 0), 1, mk_rsp(2, 128, 2, ERR_NONE)});
    dir_tab.push_back('{0, 0, mk_req(KIND_ADD, 1, 3, 0), 1,
                        mk_rsp(0, 128, 2, ERR_NO_COLOR)});
    dir_tab.push_back('{0, 0, mk_req(KIND_ADD, 2, 3, 0), 0, none});
    dir_tab.push_back('{0, 0, mk_req(KIND_ADD, 3, 0, 0), 0, none});
    dir_tab.push_back('{0, 0, mk_req(KIND_ADD, 0, 2, 0), 0, none});
    dir_tab.push_back('{1, 2, no_req, 0, none});
    dir_tab.push_back('{0, 0, mk_req(KIND_ADD, 0, 2, 0), 0, none});
    dir_tab.push_back('{0, 0, mk_req(KIND_ADD, 0, 3, 0), 0, none});
    dir_tab.push_back('{0, 0, mk_req(KIND_ADD, 4, 0, 0), 0, none});
    dir_tab.push_back('{0, 0, mk_req(KIND_ADD, 4, 2, 0), 0, none});
    dir_tab.push_back('{0, 0, mk_req(KIND_ADD, 3, 4, 0), 0, none});
    dir_tab.push_back('{0, 0, mk_req(KIND_READ, 4, 0, 3), 0, none});

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        wait_idle();
        write_max_degree(dir_tab[i].cfg_val);
      end else begin
        send_request(dir_tab[i].r, dir_tab[i].typed, dir_tab[i].o, 1'b0);
      end
    end

    // random phases: small vertex sets so paths and fans get exercised
    for (ph = 0; ph < 9; ph++) begin
      wait_idle();
      write_max_degree(md_list[ph]);
      quiet = (ph % 3 == 2);
      out_busy = quiet;
      lim = (md_list[ph] + 1 > MAX_COLORS) ? MAX_COLORS : md_list[ph] + 1;
      send_request(mk_req(KIND_CLEAR, 0, 0, 0), 0, none, quiet);
      n = $urandom_range(3, 12);
      base = $urandom_range(0, 127);
      stride = 2 * $urandom_range(0, 15) + 1;
      for (i = 0; i < 127; i++) begin
        sel = $urandom_range(0, 199);
        a = (base + $urandom_range(0, n - 1) * stride) % 128;
        b = (base + $urandom_range(0, n - 1) * stride) % 128;
        q = $urandom_range(1, lim);
        if (sel < 168) begin
          r = mk_req(KIND_ADD, a, b, $urandom_range(0, 127));
        end else if (sel < 184) begin
          r = mk_req(KIND_READ, a, $urandom_range(0, 127),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : q);
        end else if (sel < 193) begin
          r = mk_req(KIND_ADD, $urandom_range(0, 127), $urandom_range(0, 127),
                     $urandom_range(0, 127));
        end else if (sel < 199) begin
          r = mk_req(KIND_NOP, $urandom_range(0, 127), $urandom_range(0, 127),
                     $urandom_range(0, 127));
        end else begin
          r = mk_req(KIND_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127),
                     $urandom_range(0, 127));
        end
        send_request(r, 0, none, quiet);
      end
    end

    // drain
    request.valid <= 1'b0;
    out_busy = 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/vec_pkg.sv
rtl/core/vec_stream_if.sv
rtl/core/vec_ram.sv
rtl/core/vizing_edge_colorer_unit.sv
tb/sv/tb.sv
